>>> rtl/core/xsc_pkg.sv
// ----------------------------------------------------------------------------
// XMODEM sender control package
// Shared codes, widths and structs for the XMODEM-CRC sender control core.
// ----------------------------------------------------------------------------
`default_nettype none

package xsc_pkg;

  // Field widths.
  localparam int unsigned CMD_W    = 3;
  localparam int unsigned BYTE_W   = 8;
  localparam int unsigned ACT_W    = 3;
  localparam int unsigned STAT_W   = 3;
  localparam int unsigned PHASE_W  = 3;
  localparam int unsigned ATT_W    = 9;
  localparam int unsigned ACKS_W   = 16;
  localparam int unsigned MAXATT_W = 8;

  // Register reset value.
  localparam logic [MAXATT_W-1:0] MAX_ATTEMPTS_RST = 8'd10;

  // Protocol bytes.
  localparam logic [BYTE_W-1:0] CODE_C   = 8'h43;
  localparam logic [BYTE_W-1:0] CODE_ACK = 8'h06;
  localparam logic [BYTE_W-1:0] CODE_CAN = 8'h18;

  // Commands.
  localparam logic [CMD_W-1:0] CMD_START   = 3'd0;
  localparam logic [CMD_W-1:0] CMD_REPLY   = 3'd1;
  localparam logic [CMD_W-1:0] CMD_PKT_RDY = 3'd2;
  localparam logic [CMD_W-1:0] CMD_EOD     = 3'd3;
  localparam logic [CMD_W-1:0] CMD_RD_ERR  = 3'd4;

  // Phases.
  localparam logic [PHASE_W-1:0] PH_IDLE  = 3'd0;
  localparam logic [PHASE_W-1:0] PH_WAITC = 3'd1;
  localparam logic [PHASE_W-1:0] PH_FETCH = 3'd2;
  localparam logic [PHASE_W-1:0] PH_SENT  = 3'd3;
  localparam logic [PHASE_W-1:0] PH_CAN1  = 3'd4;
  localparam logic [PHASE_W-1:0] PH_DRAIN = 3'd5;
  localparam logic [PHASE_W-1:0] PH_EOT   = 3'd6;

  // Actions.
  localparam logic [ACT_W-1:0] ACT_NONE   = 3'd0;
  localparam logic [ACT_W-1:0] ACT_XMIT   = 3'd1;
  localparam logic [ACT_W-1:0] ACT_FETCH  = 3'd2;
  localparam logic [ACT_W-1:0] ACT_CAN    = 3'd3;
  localparam logic [ACT_W-1:0] ACT_ACK    = 3'd4;
  localparam logic [ACT_W-1:0] ACT_EOT    = 3'd5;
  localparam logic [ACT_W-1:0] ACT_REBOOT = 3'd6;

  // Status codes.
  localparam logic [STAT_W-1:0] ST_BUSY    = 3'd0;
  localparam logic [STAT_W-1:0] ST_DONE    = 3'd1;
  localparam logic [STAT_W-1:0] ST_NOSTART = 3'd2;
  localparam logic [STAT_W-1:0] ST_CANCEL  = 3'd3;
  localparam logic [STAT_W-1:0] ST_ERRORS  = 3'd4;
  localparam logic [STAT_W-1:0] ST_EOTFAIL = 3'd5;
  localparam logic [STAT_W-1:0] ST_READERR = 3'd6;

  // Sequencer state.
  typedef struct packed {
    logic [PHASE_W-1:0] phase;
    logic [ATT_W-1:0]   attempts;
    logic [ACKS_W-1:0]  acks;
  } xsc_state_t;

  // Outcome of one item: action, status and whether the action repeats three times.
  typedef struct packed {
    logic [ACT_W-1:0]  action;
    logic [STAT_W-1:0] status;
    logic              three;
  } xsc_result_t;

endpackage

`default_nettype wire

>>> rtl/core/xsc_decide.sv
// ----------------------------------------------------------------------------
// XMODEM sender control decision logic
// Computes the next sequencer state and the outcome for one registered item.
// ----------------------------------------------------------------------------
`default_nettype none

module xsc_decide (
  input  wire logic [xsc_pkg::CMD_W-1:0]    cmd,
  input  wire logic [xsc_pkg::BYTE_W-1:0]   reply_byte,
  input  wire logic [xsc_pkg::MAXATT_W-1:0] max_attempts,
  input  wire xsc_pkg::xsc_state_t          cur,
  output xsc_pkg::xsc_state_t               nxt,
  output xsc_pkg::xsc_result_t              res
);
  import xsc_pkg::*;

  logic [ATT_W-1:0] att_inc;
  logic [ATT_W-1:0] max_ext;
  logic [ATT_W-1:0] eot_limit;
  logic             max_zero;
  logic             is_reply;

  assign att_inc   = cur.attempts + 9'd1;
  assign max_ext   = {1'b0, max_attempts};
  assign eot_limit = {max_attempts, 1'b0};
  assign max_zero  = (max_attempts == '0);
  assign is_reply  = (cmd == CMD_REPLY);

  // One transition per item; unexpected commands leave the state alone.
  always_comb begin
    nxt = cur;
    res = '{action: ACT_NONE, status: ST_BUSY, three: 1'b0};
    case (cur.phase)
      PH_IDLE: begin
        if (cmd == CMD_START) begin
          nxt.attempts = '0;
          nxt.acks     = '0;
          if (max_zero) begin
            res.status = ST_NOSTART;
          end else begin
            nxt.phase = PH_WAITC;
          end
        end
      end
      PH_WAITC: begin
        if (is_reply) begin
          nxt.attempts = att_inc;
          if (reply_byte == CODE_C) begin
            nxt.phase  = PH_FETCH;
            res.action = ACT_FETCH;
          end else if (att_inc >= max_ext) begin
            res.status = ST_NOSTART;
          end
        end
      end
      PH_FETCH: begin
        if (cmd == CMD_PKT_RDY) begin
          if (max_zero) begin
            res = '{action: ACT_CAN, status: ST_ERRORS, three: 1'b1};
          end else begin
            nxt.attempts = 9'd1;
            nxt.phase    = PH_SENT;
            res.action   = ACT_XMIT;
          end
        end else if (cmd == CMD_EOD) begin
          if (max_zero) begin
            res.status = ST_EOTFAIL;
          end else begin
            nxt.attempts = 9'd1;
            nxt.phase    = PH_EOT;
            res.action   = ACT_EOT;
          end
        end else if (cmd == CMD_RD_ERR) begin
          res = '{action: ACT_CAN, status: ST_READERR, three: 1'b1};
        end
      end
      PH_SENT, PH_CAN1: begin
        if (is_reply) begin
          if (cur.phase == PH_SENT && reply_byte == CODE_ACK) begin
            if (cur.acks != '1) begin
              nxt.acks = cur.acks + 16'd1;
            end
            nxt.phase  = PH_FETCH;
            res.action = ACT_FETCH;
          end else if (reply_byte == CODE_CAN) begin
            // A first CAN waits for a second; the second starts the drain.
            nxt.phase = (cur.phase == PH_SENT) ? PH_CAN1 : PH_DRAIN;
          end else if (cur.attempts < max_ext) begin
            nxt.attempts = att_inc;
            nxt.phase    = PH_SENT;
            res.action   = ACT_XMIT;
          end else begin
            res = '{action: ACT_CAN, status: ST_ERRORS, three: 1'b1};
          end
        end
      end
      PH_DRAIN: begin
        if (is_reply) begin
          res.action = ACT_ACK;
          res.status = ST_CANCEL;
        end
      end
      PH_EOT: begin
        if (is_reply) begin
          if (reply_byte == CODE_ACK) begin
            res.action = ACT_REBOOT;
            res.status = ST_DONE;
          end else if (cur.attempts < eot_limit) begin
            nxt.attempts = att_inc;
            res.action   = ACT_EOT;
          end else begin
            res.status = ST_EOTFAIL;
          end
        end
      end
      default: begin
        nxt.phase = PH_IDLE;
      end
    endcase
    // Any terminal status ends the session.
    if (res.status != ST_BUSY) begin
      nxt.phase = PH_IDLE;
    end
  end

endmodule

`default_nettype wire

>>> rtl/core/xsc_out.sv
// ----------------------------------------------------------------------------
// XMODEM sender control result stage
// Holds one item's outcome and presents it as one or three result items.
// ----------------------------------------------------------------------------
`default_nettype none

module xsc_out (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire logic                        load,
  input  wire xsc_pkg::xsc_result_t        load_res,
  input  wire logic [xsc_pkg::ACKS_W-1:0]  load_acks,
  output logic                             free,
  output logic                             out_valid,
  input  wire logic                        out_stall,
  output logic [xsc_pkg::ACT_W-1:0]        action,
  output logic [xsc_pkg::STAT_W-1:0]       status,
  output logic [xsc_pkg::ACKS_W-1:0]       packets_sent,
  output logic                             last
);
  import xsc_pkg::*;

  xsc_result_t       res_q;
  logic [ACKS_W-1:0] acks_q;
  logic [1:0]        idx;
  logic [1:0]        idx_next;
  logic              out_take;

  assign out_take = out_valid && !out_stall;
  assign last     = !res_q.three || (idx == 2'd2);
  assign free     = !out_valid || (out_take && last);

  assign action       = res_q.action;
  assign status       = res_q.status;
  assign packets_sent = acks_q;

  // Burst position within a three-item result.
  always_comb begin
    idx_next = idx;
    if (load) begin
      idx_next = 2'd0;
    end else if (out_take && !last) begin
      idx_next = idx + 2'd1;
    end
  end

  // Control registers.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
      idx       <= 2'd0;
    end else begin
      idx <= idx_next;
      if (load) begin
        out_valid <= 1'b1;
      end else if (out_take && last) begin
        out_valid <= 1'b0;
      end
    end
  end

  // Payload registers.
  always_ff @(posedge clk) begin
    if (load) begin
      res_q  <= load_res;
      acks_q <= load_acks;
    end
  end

  a_idx_range: assert property (@(posedge clk) disable iff (rst) idx != 2'd3)
    else $error("burst index out of range");

  a_single_idx: assert property (@(posedge clk) disable iff (rst)
    out_valid && !res_q.three |-> idx == 2'd0)
    else $error("single result with nonzero burst index");

  a_burst_can: assert property (@(posedge clk) disable iff (rst)
    out_valid && res_q.three |-> action == ACT_CAN && status != ST_BUSY)
    else $error("burst result that is not a terminal CAN");

  a_burst_step: assert property (@(posedge clk) disable iff (rst)
    out_take && !last |=> out_valid && idx == $past(idx) + 2'd1)
    else $error("burst did not advance");

endmodule

`default_nettype wire

>>> rtl/core/xmodem_sender_control_core.sv
// ----------------------------------------------------------------------------
// XMODEM sender control core
// Control sequencer of an XMODEM-CRC sender: start, retries, cancel, EOT.
// ----------------------------------------------------------------------------
// Path: an accepted item passes the input register, then the result register.
// Throughput: one item per cycle while the output is not stalled; an item that
//   ends in three CANs holds the result register until all three are taken.
// Reset: synchronous; returns to idle, clears counters, max_attempts = 10.
// ----------------------------------------------------------------------------
`default_nettype none

module xmodem_sender_control_core (
  input  wire logic                          clk,
  input  wire logic                          rst,
  input  wire logic                          cfg_valid,
  output logic                               cfg_ready,
  input  wire logic [xsc_pkg::MAXATT_W-1:0]  cfg_data,
  input  wire logic                          in_valid,
  output logic                               in_stall,
  input  wire logic [xsc_pkg::CMD_W-1:0]     cmd,
  input  wire logic [xsc_pkg::BYTE_W-1:0]    reply_byte,
  output logic                               out_valid,
  input  wire logic                          out_stall,
  output logic [xsc_pkg::ACT_W-1:0]          action,
  output logic [xsc_pkg::STAT_W-1:0]         status,
  output logic [xsc_pkg::ACKS_W-1:0]         packets_sent,
  output logic                               last
);
  import xsc_pkg::*;

  logic [MAXATT_W-1:0] max_attempts;
  logic                in_q_valid;
  logic [CMD_W-1:0]    cmd_q;
  logic [BYTE_W-1:0]   byte_q;
  logic                in_take;
  logic                move;
  logic                out_free;
  xsc_state_t          st;
  xsc_state_t          st_next;
  xsc_result_t         step_res;

  // The user must write the register only while idle; the block does not enforce this, so writes are always taken.
  assign cfg_ready = 1'b1;

  assign move     = in_q_valid && out_free;
  assign in_stall = in_q_valid && !out_free;
  assign in_take  = in_valid && !in_stall;

  // Configuration register.
  always_ff @(posedge clk) begin
    if (rst) begin
      max_attempts <= MAX_ATTEMPTS_RST;
    end else if (cfg_valid && cfg_ready) begin
      max_attempts <= cfg_data;
    end
  end

  // Input register.
  always_ff @(posedge clk) begin
    if (rst) begin
      in_q_valid <= 1'b0;
    end else if (in_take) begin
      in_q_valid <= 1'b1;
    end else if (move) begin
      in_q_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (in_take) begin
      cmd_q  <= cmd;
      byte_q <= reply_byte;
    end
  end

  // Sequencer state advances as the item moves to the result register.
  always_ff @(posedge clk) begin
    if (rst) begin
      st <= '{phase: PH_IDLE, attempts: '0, acks: '0};
    end else if (move) begin
      st <= st_next;
    end
  end

  xsc_decide u_decide (
    .cmd          (cmd_q),
    .reply_byte   (byte_q),
    .max_attempts (max_attempts),
    .cur          (st),
    .nxt          (st_next),
    .res          (step_res)
  );

  xsc_out u_out (
    .clk          (clk),
    .rst          (rst),
    .load         (move),
    .load_res     (step_res),
    .load_acks    (st_next.acks),
    .free         (out_free),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .action       (action),
    .status       (status),
    .packets_sent (packets_sent),
    .last         (last)
  );

  a_stall_full: assert property (@(posedge clk) disable iff (rst)
    in_stall |-> in_q_valid && out_valid)
    else $error("input stalled with room downstream");

  a_state_hold: assert property (@(posedge clk) disable iff (rst)
    !$past(move) && !$past(rst) |-> st == $past(st))
    else $error("state changed without an item");

  a_terminal_idle: assert property (@(posedge clk) disable iff (rst)
    move && step_res.status != ST_BUSY |=> st.phase == PH_IDLE)
    else $error("terminal status did not return to idle");

endmodule

`default_nettype wire
